// ===== rtl/kms_pkg.sv =====
// shared types, constants and key position table for the key matrix scanner
package kms_pkg;

   // operation codes
   localparam logic OP_COLUMN_WRITE = 1'b0;
   localparam logic OP_FKEY_POLL    = 1'b1;

   // scan code constants
   localparam logic [6:0] FKEY_FIRST  = 7'd59;
   localparam logic [6:0] FKEY_LAST   = 7'd68;
   localparam logic [6:0] FKEY_BASE   = 7'd58;
   localparam logic [7:0] KEY_MASK    = 8'h7f;
   localparam logic [7:0] RELEASE_BIT = 8'h80;
   localparam logic [7:0] NO_KEY      = 8'd255;
   localparam logic [7:0] NO_EVENT    = 8'd0;

   // input transfer payload
   typedef struct packed {
      logic       opcode;
      logic [7:0] column_drive;
      logic [7:0] key_code;
      logic       comparator_in;
   } req_type;

   // result transfer payload
   typedef struct packed {
      logic [7:0] row_pattern;
      logic [3:0] fkey_number;
      logic       bad_key_code;
   } rsp_type;

   // decoded key event, from the key map to the matrix
   typedef struct packed {
      logic       key_apply;
      logic       key_release;
      logic [2:0] key_row;
      logic [2:0] key_col;
      logic       fkey_press;
      logic [3:0] fkey_num;
      logic       bad_code;
   } event_type;

   // key number to row * 8 + column, NO_KEY where the key has no position
   function automatic logic [7:0] key_position(input logic [6:0] key);
      logic [7:0] pos;
      unique case (key)
         7'd1:    pos = 8'd50;
         7'd2:    pos = 8'd1;
         7'd3:    pos = 8'd2;
         7'd4:    pos = 8'd3;
         7'd5:    pos = 8'd4;
         7'd6:    pos = 8'd5;
         7'd7:    pos = 8'd6;
         7'd8:    pos = 8'd7;
         7'd9:    pos = 8'd8;
         7'd10:   pos = 8'd9;
         7'd11:   pos = 8'd0;
         7'd12:   pos = 8'd13;
         7'd13:   pos = 8'd10;
         7'd14:   pos = 8'd49;
         7'd16:   pos = 8'd33;
         7'd17:   pos = 8'd39;
         7'd18:   pos = 8'd21;
         7'd19:   pos = 8'd34;
         7'd20:   pos = 8'd36;
         7'd21:   pos = 8'd41;
         7'd22:   pos = 8'd37;
         7'd23:   pos = 8'd25;
         7'd24:   pos = 8'd31;
         7'd25:   pos = 8'd32;
         7'd26:   pos = 8'd16;
         7'd28:   pos = 8'd48;
         7'd30:   pos = 8'd17;
         7'd31:   pos = 8'd35;
         7'd32:   pos = 8'd20;
         7'd33:   pos = 8'd22;
         7'd34:   pos = 8'd23;
         7'd35:   pos = 8'd24;
         7'd36:   pos = 8'd26;
         7'd37:   pos = 8'd27;
         7'd38:   pos = 8'd28;
         7'd39:   pos = 8'd11;
         7'd42:   pos = 8'd55;
         7'd44:   pos = 8'd42;
         7'd45:   pos = 8'd40;
         7'd46:   pos = 8'd19;
         7'd47:   pos = 8'd38;
         7'd48:   pos = 8'd18;
         7'd49:   pos = 8'd30;
         7'd50:   pos = 8'd29;
         7'd51:   pos = 8'd12;
         7'd52:   pos = 8'd14;
         7'd53:   pos = 8'd15;
         7'd57:   pos = 8'd47;
         7'd72:   pos = 8'd43;
         7'd75:   pos = 8'd45;
         7'd77:   pos = 8'd46;
         7'd80:   pos = 8'd44;
         default: pos = NO_KEY;
      endcase
      return pos;
   endfunction

endpackage

// ===== rtl/kms_keymap.sv =====
// scan code decoder: key position lookup and function key detection
module kms_keymap import kms_pkg::*; #(
   parameter int MATRIX_ROWS = 7
) (
   input  logic [7:0] key_code,
   output event_type  key_event
);

   logic [6:0] key_num;
   logic [7:0] key_pos;
   logic       is_release;
   logic       is_fkey;
   logic       pos_bad;

   assign key_num    = key_code[6:0] & KEY_MASK[6:0];
   assign is_release = (key_code & RELEASE_BIT) != 8'd0;
   assign is_fkey    = (key_num >= FKEY_FIRST) && (key_num <= FKEY_LAST);
   assign key_pos    = key_position(key_num);

   // no position, or a row the matrix does not have
   assign pos_bad = (key_pos == NO_KEY) || (key_pos[7:6] != 2'd0) ||
                    ({1'b0, key_pos[5:3]} >= 4'(MATRIX_ROWS));

   // event decode
   always_comb begin
      key_event             = '0;
      key_event.key_release = is_release;
      key_event.key_row     = key_pos[5:3];
      key_event.key_col     = key_pos[2:0];
      key_event.fkey_num    = 4'(key_num - FKEY_BASE);
      priority if (key_code == NO_EVENT) begin
         key_event.key_apply = 1'b0;
      end else if (is_fkey) begin
         // function key release is ignored
         key_event.fkey_press = !is_release;
      end else if (pos_bad) begin
         key_event.bad_code = 1'b1;
      end else begin
         key_event.key_apply = 1'b1;
      end
   end

endmodule

// ===== rtl/kms_matrix.sv =====
// key matrix and function key latch, with the row scan of the updated matrix
module kms_matrix import kms_pkg::*; #(
   parameter int MATRIX_ROWS = 7
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      item_valid,
   input  req_type   item,
   input  event_type key_event,
   output rsp_type   result
);

   logic [7:0] matrix_ff [MATRIX_ROWS];
   logic [7:0] matrix_in [MATRIX_ROWS];
   logic [3:0] latch_ff;
   logic [3:0] latch_in;
   logic [7:0] key_bit;
   logic [7:0] drive_low;
   logic [7:0] row_hits;
   logic       is_write;

   assign is_write  = item_valid && (item.opcode == OP_COLUMN_WRITE);
   assign key_bit   = 8'd1 << key_event.key_col;
   assign drive_low = ~item.column_drive;

   // matrix update: press clears, release sets
   always_comb begin
      for (int r = 0; r < MATRIX_ROWS; r++) begin
         matrix_in[r] = matrix_ff[r];
         if (is_write && key_event.key_apply && (key_event.key_row == 3'(r))) begin
            if (key_event.key_release) begin
               matrix_in[r] = matrix_ff[r] | key_bit;
            end else begin
               matrix_in[r] = matrix_ff[r] & ~key_bit;
            end
         end
      end
   end

   // row scan against the updated matrix, row 7 never reported
   always_comb begin
      row_hits = 8'd0;
      for (int r = 0; r < MATRIX_ROWS; r++) begin
         if (r < 7) begin
            row_hits[r] = (drive_low & matrix_in[r]) == drive_low;
         end
      end
   end

   // function key latch: poll clears, press fills an empty latch
   always_comb begin
      latch_in = latch_ff;
      if (item_valid) begin
         unique case (item.opcode)
            OP_FKEY_POLL: begin
               latch_in = 4'd0;
            end
            OP_COLUMN_WRITE: begin
               if (key_event.fkey_press && (latch_ff == 4'd0)) begin
                  latch_in = key_event.fkey_num;
               end
            end
            default: latch_in = latch_ff;
         endcase
      end
   end

   // result forming
   always_comb begin
      result = '0;
      if (item.opcode == OP_FKEY_POLL) begin
         result.fkey_number = latch_ff;
      end else begin
         result.row_pattern  = {item.comparator_in, row_hits[6:0]};
         result.bad_key_code = key_event.bad_code;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MATRIX_ROWS; r++) begin
            matrix_ff[r] <= 8'hff;
         end
         latch_ff <= 4'd0;
      end else begin
         for (int r = 0; r < MATRIX_ROWS; r++) begin
            matrix_ff[r] <= matrix_in[r];
         end
         latch_ff <= latch_in;
      end
   end

endmodule

// ===== rtl/keyboard_matrix_scanner.sv =====
// top level of the key matrix scanner: request and result registers
//
// Usage:
//  - a request is transferred at a rising edge with start high and busy low;
//    busy stays low, so one request may be transferred in every cycle
//  - opcode 0 is a column write: the scan code is applied to the key matrix
//    and the row pattern of the updated matrix is returned, bit 7 being the
//    comparator level; an unmapped code sets bad_key_code and leaves the
//    matrix alone
//  - opcode 1 polls the function key latch, returns it and clears it
//  - each result appears on rsp_data for exactly one cycle with rsp_valid
//    high, after passing the request register and the result register;
//    results come out in request order
//  - throughput is one item per cycle: the request register feeds a single
//    pass of key lookup, matrix update and row compare into the result
//    register, and the matrix registers are updated in the same cycle
//  - the receiver cannot stall; every result is transferred as it appears
//  - synchronous reset releases all keys, empties the function key latch
//    and drops any request or result in flight
module keyboard_matrix_scanner import kms_pkg::*; #(
   parameter int MATRIX_ROWS = 7
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic      req_valid_ff;
   logic      req_valid_in;
   req_type   req_ff;
   req_type   req_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   event_type key_event;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;
   assign req_in       = req_valid_in ? req_data : req_ff;
   assign rsp_valid_in = req_valid_ff;

   // scan code decode
   kms_keymap #(
      .MATRIX_ROWS(MATRIX_ROWS)
   ) u_keymap (
      .key_code(req_ff.key_code),
      .key_event(key_event)
   );

   // matrix state and row scan
   kms_matrix #(
      .MATRIX_ROWS(MATRIX_ROWS)
   ) u_matrix (
      .clock(clock),
      .reset(reset),
      .item_valid(req_valid_ff),
      .item(req_ff),
      .key_event(key_event),
      .result(rsp_in)
   );

   // request and result control
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // every transfer in is followed by a result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("result strobe missing after request transfer");

   // a result strobe only follows a registered request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_valid_ff))
      else $error("result strobe without request");

   // poll results carry no row pattern or flag
   a_poll_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.fkey_number != 4'd0)) |->
         (rsp_data.row_pattern == 8'd0 && !rsp_data.bad_key_code))
      else $error("poll result carries column write fields");

   // latched function key stays within one to ten
   a_fkey_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.fkey_number <= 4'd10))
      else $error("function key out of range");

endmodule

// ===== dv/kms_scoreboard_pkg.sv =====
// scoreboard for the key matrix scanner: matrix predictor and in-order result check
`timescale 1ns / 100ps

package kms_scoreboard_pkg;
   import kms_pkg::*;

   localparam int TB_MATRIX_ROWS = 7;
   localparam int KEY_MAP_SIZE   = 81;
   localparam int REPORT_LIMIT   = 10;

   class key_matrix_scoreboard;
      // row * 8 + column per key number, NO_KEY where the key has no position
      logic [7:0]  key_map [0:KEY_MAP_SIZE-1];
      logic [7:0]  key_rows [TB_MATRIX_ROWS];
      logic [3:0]  fkey_latch;
      rsp_type     expected_reads[$];
      int unsigned failures;
      int unsigned checked;

      function new();
         key_map = '{
            NO_KEY, 8'd50,  8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6,
            8'd7,   8'd8,   8'd9,   8'd0,   8'd13,  8'd10,  8'd49,  NO_KEY,
            8'd33,  8'd39,  8'd21,  8'd34,  8'd36,  8'd41,  8'd37,  8'd25,
            8'd31,  8'd32,  8'd16,  NO_KEY, 8'd48,  NO_KEY, 8'd17,  8'd35,
            8'd20,  8'd22,  8'd23,  8'd24,  8'd26,  8'd27,  8'd28,  8'd11,
            NO_KEY, NO_KEY, 8'd55,  NO_KEY, 8'd42,  8'd40,  8'd19,  8'd38,
            8'd18,  8'd30,  8'd29,  8'd12,  8'd14,  8'd15,  NO_KEY, NO_KEY,
            NO_KEY, 8'd47,  NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY,
            NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY,
            8'd43,  NO_KEY, NO_KEY, 8'd45,  NO_KEY, 8'd46,  NO_KEY, NO_KEY,
            8'd44
         };
         foreach (key_rows[i]) key_rows[i] = 8'hff;
         fkey_latch = '0;
         failures   = 0;
         checked    = 0;
      endfunction

      // applies one request to the matrix copy and returns the read-back it causes
      function rsp_type key_event_result(req_type item);
         rsp_type    res;
         logic [6:0] key;
         logic [7:0] pos;
         logic [7:0] low_cols;
         res = '0;
         if (item.opcode == OP_FKEY_POLL) begin
            res.fkey_number = fkey_latch;
            fkey_latch = '0;
            return res;
         end
         key = item.key_code[6:0];
         // key event: function keys latch, mapped keys move the matrix
         if (item.key_code != NO_EVENT) begin
            if (key >= FKEY_FIRST && key <= FKEY_LAST) begin
               if (item.key_code[7] == 1'b0 && fkey_latch == '0)
                  fkey_latch = 4'(key - FKEY_BASE);
            end else if (int'(key) >= KEY_MAP_SIZE) begin
               res.bad_key_code = 1'b1;
            end else begin
               pos = key_map[key];
               if (pos == NO_KEY || int'(pos[7:3]) >= TB_MATRIX_ROWS) begin
                  res.bad_key_code = 1'b1;
               end else if (item.key_code[7]) begin
                  key_rows[pos[7:3]][pos[2:0]] = 1'b1;
               end else begin
                  key_rows[pos[7:3]][pos[2:0]] = 1'b0;
               end
            end
         end
         // row compare against the columns driven low
         low_cols = ~item.column_drive;
         for (int r = 0; r < TB_MATRIX_ROWS && r < 7; r++) begin
            if ((low_cols & key_rows[r]) == low_cols) res.row_pattern[r] = 1'b1;
         end
         res.row_pattern[7] = item.comparator_in;
         return res;
      endfunction

      function void note_request(req_type item);
         expected_reads.push_back(key_event_result(item));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_reads.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected result: row %02h fkey %0d bad %0b",
                        got.row_pattern, got.fkey_number, got.bad_key_code);
            return;
         end
         want = expected_reads.pop_front();
         checked++;
         if (got.row_pattern !== want.row_pattern || got.fkey_number !== want.fkey_number ||
             got.bad_key_code !== want.bad_key_code) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("mismatch on result %0d: expected row %02h fkey %0d bad %0b, got row %02h fkey %0d bad %0b",
                        checked, want.row_pattern, want.fkey_number, want.bad_key_code,
                        got.row_pattern, got.fkey_number, got.bad_key_code);
         end
      endfunction

      function int pending();
         return expected_reads.size();
      endfunction
   endclass

endpackage

// ===== dv/tb_top.sv =====
// testbench top for the key matrix scanner: stimulus, pacing, result monitor
`timescale 1ns / 100ps

module tb_top;
   import kms_pkg::*;
   import kms_scoreboard_pkg::*;

   localparam int RANDOM_ITEMS = 1900;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   key_matrix_scoreboard sb = new();

   int unsigned burst_left = 1;
   int unsigned n_items;
   int unsigned n_polls;
   int unsigned n_fkeys_read;
   int unsigned n_bad_flags;
   logic [6:0]  mapped_keys[$];

   keyboard_matrix_scanner #(.MATRIX_ROWS(TB_MATRIX_ROWS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // 12 ns clock
   always #6 clock = ~clock;

   // result monitor: every strobed result is a transfer
   always @(posedge clock) begin
      if (reset == 1'b0 && rsp_valid === 1'b1) begin
         sb.check_result(rsp_data);
         if (rsp_data.fkey_number != 0) n_fkeys_read++;
         if (rsp_data.bad_key_code) n_bad_flags++;
      end
   end

   function automatic req_type make_req(logic op, logic [7:0] drive, logic [7:0] code,
                                        logic comp);
      req_type item;
      item.opcode        = op;
      item.column_drive  = drive;
      item.key_code      = code;
      item.comparator_in = comp;
      return item;
   endfunction

   // one transfer, then a random gap when the current burst runs out
   task automatic send_item(input req_type item);
      int unsigned gap;
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(item);
      n_items++;
      if (item.opcode == OP_FKEY_POLL) n_polls++;
      burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            start    <= 1'b0;
            req_data <= req_type'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // extremes, every operation and each special case
   task automatic run_directed();
      send_item(make_req(OP_COLUMN_WRITE, 8'hff, NO_EVENT, 1'b0));
      send_item(make_req(OP_COLUMN_WRITE, 8'h00, NO_EVENT, 1'b1));
      send_item(make_req(OP_COLUMN_WRITE, 8'hfb, 8'd1, 1'b0));
      send_item(make_req(OP_COLUMN_WRITE, 8'hef, 8'd80, 1'b1));
      send_item(make_req(OP_COLUMN_WRITE, 8'h7f, 8'd57, 1'b0));
      // function key latch: fill, press while full, release ignored
      send_item(make_req(OP_COLUMN_WRITE, 8'h00, 8'd59, 1'b0));
      send_item(make_req(OP_COLUMN_WRITE, 8'h00, 8'd68, 1'b1));
      send_item(make_req(OP_COLUMN_WRITE, 8'h00, RELEASE_BIT | 8'd59, 1'b0));
      send_item(make_req(OP_FKEY_POLL, 8'h00, 8'h00, 1'b0));
      send_item(make_req(OP_FKEY_POLL, 8'hff, 8'hff, 1'b1));
      send_item(make_req(OP_COLUMN_WRITE, 8'hfe, 8'd68, 1'b0));
      send_item(make_req(OP_COLUMN_WRITE, 8'hfe, RELEASE_BIT | 8'd68, 1'b0));
      send_item(make_req(OP_FKEY_POLL, 8'h5a, 8'd59, 1'b1));
      // codes with no matrix position
      send_item(make_req(OP_COLUMN_WRITE, 8'h00, RELEASE_BIT, 1'b0));
      send_item(make_req(OP_COLUMN_WRITE, 8'h00, 8'd81, 1'b1));
      send_item(make_req(OP_COLUMN_WRITE, 8'hff, 8'd127, 1'b0));
      send_item(make_req(OP_COLUMN_WRITE, 8'h00, 8'd255, 1'b1));
      send_item(make_req(OP_COLUMN_WRITE, 8'h00, 8'd15, 1'b0));
      send_item(make_req(OP_COLUMN_WRITE, 8'h00, RELEASE_BIT | 8'd15, 1'b0));
      // releases put the matrix back to all open
      send_item(make_req(OP_COLUMN_WRITE, 8'hfb, RELEASE_BIT | 8'd1, 1'b1));
      send_item(make_req(OP_COLUMN_WRITE, 8'hef, RELEASE_BIT | 8'd80, 1'b0));
      send_item(make_req(OP_COLUMN_WRITE, 8'h00, RELEASE_BIT | 8'd57, 1'b1));
   endtask

   function automatic logic [7:0] pick_drive();
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind < 5) return ~(8'h01 << $urandom_range(0, 7));
      if (kind < 7) return 8'($urandom);
      if (kind == 7) return 8'h00;
      if (kind == 8) return 8'hff;
      return ~((8'h01 << $urandom_range(0, 7)) | (8'h01 << $urandom_range(0, 7)));
   endfunction

   // mostly mapped key events with random drives, plus polls and noise
   task automatic run_random();
      int unsigned kind;
      logic [7:0]  code;
      logic        rel;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         kind = $urandom_range(0, 99);
         rel  = $urandom_range(0, 1);
         if (kind < 50) begin
            code = {rel, mapped_keys[$urandom_range(0, mapped_keys.size() - 1)]};
         end else if (kind < 60) begin
            code = {($urandom_range(0, 3) == 0), 7'($urandom_range(59, 68))};
         end else if (kind < 72) begin
            send_item(make_req(OP_FKEY_POLL, 8'($urandom), 8'($urandom), 1'($urandom)));
            continue;
         end else if (kind < 86) begin
            code = 8'($urandom);
         end else if (kind < 90) begin
            code = NO_EVENT;
         end else begin
            code = {rel, 7'($urandom_range(69, 127))};
         end
         send_item(make_req(OP_COLUMN_WRITE, pick_drive(), code, 1'($urandom)));
      end
   endtask

   // main sequence
   initial begin
      int unsigned waited;
      for (int k = 1; k < KEY_MAP_SIZE; k++) begin
         if (sb.key_map[k] != NO_KEY) mapped_keys.push_back(7'(k));
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      start <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < 200) begin
         @(posedge clock);
         waited++;
      end
      repeat (6) @(posedge clock);
      if (sb.pending() != 0)
         $display("%0d expected results never arrived", sb.pending());
      $display("covered %0d requests, %0d of them polls; %0d results checked",
               n_items, n_polls, sb.checked);
      $display("results flagged %0d unmapped codes and read back %0d function keys",
               n_bad_flags, n_fkeys_read);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", sb.pending());
      $display("tb_top failed");
      $finish;
   end

endmodule
